[hdl/pscmp_pkg.sv]
// shared types and constants for the pressure sensor compensation pipeline
package pscmp_pkg;

	localparam int DIV_W = 64;
	localparam int DEN_W = 31;

	localparam logic signed [26:0] FINE_OFFSET = 27'sd128000;
	localparam logic [20:0] RAW_FULL = 21'h10_0000;
	localparam logic [11:0] SCALE_DIV = 12'd3125;
	localparam logic [63:0] P1_BIAS = 64'h0000_8000_0000_0000;
	localparam logic [24:0] PRESS_MAX = 25'h1FF_FFFF;
	localparam logic signed [19:0] TEMP_MAX = 20'sd32767;
	localparam logic signed [19:0] TEMP_MIN = -20'sd32768;
	localparam logic signed [27:0] TEMP_ROUND = 28'sd128;

	typedef enum logic [1:0] {
		REG_TEMP_CAL = 2'd0,
		REG_PRESS_A  = 2'd1,
		REG_PRESS_B  = 2'd2,
		REG_PRESS_C  = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [19:0] raw_temperature;
		logic [19:0] raw_pressure;
	} psc_in_t;

	typedef struct packed {
		logic signed [15:0] temperature_centi;
		logic [24:0]        pressure_q24_8;
		logic               divide_by_zero;
	} psc_out_t;

	typedef struct packed {
		logic [15:0]        t1;
		logic signed [15:0] t2;
		logic signed [15:0] t3;
		logic [15:0]        p1;
		logic signed [15:0] p2;
		logic signed [15:0] p3;
		logic signed [15:0] p4;
		logic signed [15:0] p5;
		logic signed [15:0] p6;
		logic signed [15:0] p7;
		logic signed [15:0] p8;
		logic signed [15:0] p9;
	} cal_t;

	// fields that ride alongside the pressure datapath
	typedef struct packed {
		logic signed [15:0] temp;
		logic               zero;
	} side_t;

endpackage

[hdl/pscmp_temp.sv]
// temperature compensation stages: fine temperature, centi-degrees, pressure offset term
module pscmp_temp import pscmp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  psc_in_t            req,
	input  cal_t               cal,
	output logic               out_valid,
	output logic signed [15:0] temp,
	output logic signed [26:0] v1,
	output logic [19:0]        raw_p
);

	logic signed [17:0] d1_s1;
	logic signed [16:0] d2_s1;
	logic signed [33:0] m1_s2;
	logic [32:0]        sq_s2;
	logic signed [22:0] a1_s3;
	logic signed [37:0] m2_s3;
	logic signed [24:0] fine_s4;
	logic signed [15:0] temp_s5;
	logic signed [26:0] v1_s5;
	logic [19:0]        rawp_s1, rawp_s2, rawp_s3, rawp_s4, rawp_s5;
	logic               vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	logic signed [33:0] sq_full;
	logic signed [27:0] f5;
	logic signed [19:0] tw;
	logic signed [15:0] temp_sat;

	assign sq_full = d2_s1 * d2_s1;

	// fine * 5 + 128, then floor divide by 256
	assign f5 = (28'(fine_s4) <<< 2) + 28'(fine_s4) + TEMP_ROUND;
	assign tw = f5[27:8];

	always_comb begin
		if (tw > TEMP_MAX) begin
			temp_sat = 16'sh7FFF;
		end else if (tw < TEMP_MIN) begin
			temp_sat = 16'sh8000;
		end else begin
			temp_sat = tw[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		d1_s1   <= $signed({1'b0, req.raw_temperature[19:3]}) - $signed({1'b0, cal.t1, 1'b0});
		d2_s1   <= $signed({1'b0, req.raw_temperature[19:4]}) - $signed({1'b0, cal.t1});
		rawp_s1 <= req.raw_pressure;

		m1_s2   <= d1_s1 * cal.t2;
		sq_s2   <= sq_full[32:0];
		rawp_s2 <= rawp_s1;

		a1_s3   <= m1_s2[33:11];
		m2_s3   <= $signed({1'b0, sq_s2[32:12]}) * cal.t3;
		rawp_s3 <= rawp_s2;

		fine_s4 <= 25'(a1_s3) + 25'($signed(m2_s3[37:14]));
		rawp_s4 <= rawp_s3;

		temp_s5 <= temp_sat;
		v1_s5   <= 27'(fine_s4) - FINE_OFFSET;
		rawp_s5 <= rawp_s4;
	end

	assign out_valid = vld_s5;
	assign temp      = temp_s5;
	assign v1        = v1_s5;
	assign raw_p     = rawp_s5;

endmodule

[hdl/pscmp_press.sv]
// pressure stages ahead of the divider: dividend and divisor in 64-bit wrapping arithmetic
module pscmp_press import pscmp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic signed [15:0] temp,
	input  logic signed [26:0] v1,
	input  logic [19:0]        raw_p,
	input  cal_t               cal,
	output logic               out_valid,
	output logic [63:0]        dividend,
	output logic signed [30:0] divisor,
	output side_t              side
);

	logic signed [53:0] vsq_s1;
	logic signed [42:0] v1p5_s1, v1p2_s1, v1p5_s2, v1p2_s2, v1p5_s3, v1p2_s3;
	logic signed [43:0] lo6_s2, hi6_s2, lo3_s2, hi3_s2;
	logic [63:0]        full6_s3, full3_s3;
	logic [63:0]        v2_s4, w_s4;
	logic [63:0]        x_s5, diff_s5;
	logic [47:0]        xlo_s6, xhi_s6;
	logic [43:0]        dlo_s6, dhi_s6;
	logic [63:0]        dvd_s7;
	logic signed [30:0] dvs_s7;
	logic               zero_s7;
	logic signed [15:0] temp_s1, temp_s2, temp_s3, temp_s4, temp_s5, temp_s6, temp_s7;
	logic [19:0]        rawp_s1, rawp_s2, rawp_s3, rawp_s4;
	logic               vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	logic [20:0] pr;
	logic [63:0] prod;

	assign pr   = RAW_FULL - {1'b0, rawp_s4};
	assign prod = 64'(xlo_s6) + (64'(xhi_s6) << 32);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		vsq_s1  <= v1 * v1;
		v1p5_s1 <= v1 * cal.p5;
		v1p2_s1 <= v1 * cal.p2;
		temp_s1 <= temp;
		rawp_s1 <= raw_p;

		// square split in two 27-bit halves against p6 and p3
		lo6_s2  <= $signed({1'b0, vsq_s1[26:0]}) * cal.p6;
		hi6_s2  <= $signed({1'b0, vsq_s1[53:27]}) * cal.p6;
		lo3_s2  <= $signed({1'b0, vsq_s1[26:0]}) * cal.p3;
		hi3_s2  <= $signed({1'b0, vsq_s1[53:27]}) * cal.p3;
		v1p5_s2 <= v1p5_s1;
		v1p2_s2 <= v1p2_s1;
		temp_s2 <= temp_s1;
		rawp_s2 <= rawp_s1;

		full6_s3 <= 64'(lo6_s2) + (64'(hi6_s2) << 27);
		full3_s3 <= 64'(lo3_s2) + (64'(hi3_s2) << 27);
		v1p5_s3  <= v1p5_s2;
		v1p2_s3  <= v1p2_s2;
		temp_s3  <= temp_s2;
		rawp_s3  <= rawp_s2;

		v2_s4   <= full6_s3 + (64'(v1p5_s3) << 17) + (64'(cal.p4) << 35);
		w_s4    <= 64'($signed(full3_s3[63:8])) + (64'(v1p2_s3) << 12);
		temp_s4 <= temp_s3;
		rawp_s4 <= rawp_s3;

		x_s5    <= P1_BIAS + w_s4;
		diff_s5 <= {12'd0, pr, 31'd0} - v2_s4;
		temp_s5 <= temp_s4;

		xlo_s6  <= x_s5[31:0] * cal.p1;
		xhi_s6  <= x_s5[63:32] * cal.p1;
		dlo_s6  <= diff_s5[31:0] * SCALE_DIV;
		dhi_s6  <= diff_s5[63:32] * SCALE_DIV;
		temp_s6 <= temp_s5;

		dvd_s7  <= 64'(dlo_s6) + (64'(dhi_s6) << 32);
		dvs_s7  <= prod[63:33];
		zero_s7 <= (prod[63:33] == 31'd0);
		temp_s7 <= temp_s6;
	end

	assign out_valid = vld_s7;
	assign dividend  = dvd_s7;
	assign divisor   = dvs_s7;
	assign side.temp = temp_s7;
	assign side.zero = zero_s7;

endmodule

[hdl/pscmp_div.sv]
// pipelined signed divider, restoring, one quotient bit per stage
module pscmp_div import pscmp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic [DIV_W-1:0]       dividend,
	input  logic signed [DEN_W-1:0] divisor,
	input  side_t                  side_in,
	output logic                   out_valid,
	output logic [DIV_W-1:0]       quotient,
	output side_t                  side_out
);

	logic [DEN_W-1:0] rem_s  [0:DIV_W];
	logic [DIV_W-1:0] dq_s   [0:DIV_W];
	logic [DEN_W-1:0] dv_s   [0:DIV_W];
	logic             neg_s  [0:DIV_W];
	side_t            side_s [0:DIV_W];
	logic             vld_s  [0:DIV_W];

	logic [DIV_W-1:0] quo_q;
	side_t            side_q;
	logic             vld_q;

	// magnitudes and quotient sign
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0]  <= '0;
		dq_s[0]   <= dividend[DIV_W-1] ? ('0 - dividend) : dividend;
		dv_s[0]   <= divisor[DEN_W-1] ? ('0 - divisor) : divisor;
		neg_s[0]  <= dividend[DIV_W-1] ^ divisor[DEN_W-1];
		side_s[0] <= side_in;
	end

	for (genvar k = 0; k < DIV_W; k++) begin : g_bit
		logic [DEN_W:0] trial;
		logic           ge;

		assign trial = {rem_s[k], dq_s[k][DIV_W-1]};
		assign ge    = (trial >= {1'b0, dv_s[k]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= ge ? DEN_W'(trial - {1'b0, dv_s[k]}) : trial[DEN_W-1:0];
			dq_s[k+1]   <= {dq_s[k][DIV_W-2:0], ge};
			dv_s[k+1]   <= dv_s[k];
			neg_s[k+1]  <= neg_s[k];
			side_s[k+1] <= side_s[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_s[DIV_W];
		end
	end

	always_ff @(posedge clk) begin
		quo_q  <= neg_s[DIV_W] ? ('0 - dq_s[DIV_W]) : dq_s[DIV_W];
		side_q <= side_s[DIV_W];
	end

	assign out_valid = vld_q;
	assign quotient  = quo_q;
	assign side_out  = side_q;

endmodule

[hdl/pscmp_post.sv]
// pressure correction stages after the divider, saturation and result register
module pscmp_post import pscmp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [63:0] p,
	input  side_t       side_in,
	input  cal_t        cal,
	output logic        done,
	output psc_out_t    result
);

	logic [63:0]        aa_s1;
	logic [31:0]        ab_s1;
	logic signed [48:0] pl8_s1, ph8_s1;
	logic [63:0]        sq_s2;
	logic signed [44:0] e2_s2, e2_s3, e2_s4;
	logic signed [48:0] sl9_s3, sh9_s3;
	logic signed [38:0] e1_s4;
	logic [63:0]        sum_s5;
	logic [63:0]        p_s1, p_s2, p_s3, p_s4;
	side_t              side_s1, side_s2, side_s3, side_s4, side_s5;
	psc_out_t           res_s6;
	logic               vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	logic [63:0] ps;
	logic [63:0] e2_full, e1_full, r;
	psc_out_t    res_next;

	assign ps      = {{13{p[63]}}, p[63:13]};
	assign e2_full = 64'(pl8_s1) + (64'(ph8_s1) << 32);
	assign e1_full = 64'(sl9_s3) + (64'(sh9_s3) << 32);
	assign r       = 64'($signed(sum_s5[63:8])) + (64'(cal.p7) << 4);

	always_comb begin
		res_next.temperature_centi = side_s5.temp;
		res_next.divide_by_zero    = side_s5.zero;
		if (side_s5.zero || r[63]) begin
			res_next.pressure_q24_8 = '0;
		end else if (r > 64'(PRESS_MAX)) begin
			res_next.pressure_q24_8 = PRESS_MAX;
		end else begin
			res_next.pressure_q24_8 = r[24:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		// square mod 2^64 from 32-bit halves: lo*lo + (lo*hi << 33)
		aa_s1   <= ps[31:0] * ps[31:0];
		ab_s1   <= 32'(ps[31:0] * ps[63:32]);
		pl8_s1  <= $signed({1'b0, p[31:0]}) * cal.p8;
		ph8_s1  <= $signed({1'b0, p[63:32]}) * cal.p8;
		p_s1    <= p;
		side_s1 <= side_in;

		sq_s2   <= aa_s1 + {ab_s1[30:0], 33'd0};
		e2_s2   <= e2_full[63:19];
		p_s2    <= p_s1;
		side_s2 <= side_s1;

		sl9_s3  <= $signed({1'b0, sq_s2[31:0]}) * cal.p9;
		sh9_s3  <= $signed({1'b0, sq_s2[63:32]}) * cal.p9;
		e2_s3   <= e2_s2;
		p_s3    <= p_s2;
		side_s3 <= side_s2;

		e1_s4   <= e1_full[63:25];
		e2_s4   <= e2_s3;
		p_s4    <= p_s3;
		side_s4 <= side_s3;

		sum_s5  <= p_s4 + 64'(e1_s4) + 64'(e2_s4);
		side_s5 <= side_s4;

		res_s6  <= res_next;
	end

	assign done   = vld_s6;
	assign result = res_s6;

endmodule

[hdl/pressure_sensor_compensation_top.sv]
// top level: calibration registers and the compensation pipeline
// Takes one request (raw temperature and raw pressure) in every clock cycle and returns its
// result, strobed by done for a single cycle, from the result register; results leave in
// request order and cannot be held off, so capture them when done is high. busy is
// always low. The latency is set mostly by the 64-stage divider, which resolves one quotient
// bit per stage; the temperature stages, the pressure set-up and the correction after the
// divider add 5, 7 and 6 stages, the divider's sign handling two more. Calibration words are
// written through cfg_we/cfg_idx/cfg_data and must only change while no request is in flight.
module pressure_sensor_compensation_top import pscmp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  psc_in_t     request,
	output logic        done,
	output psc_out_t    result,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [63:0] cfg_data
);

	logic [47:0] temp_cal_q;
	logic [63:0] press_a_q;
	logic [63:0] press_b_q;
	logic [15:0] press_c_q;
	cal_t        cal;

	logic               t_valid;
	logic signed [15:0] t_temp;
	logic signed [26:0] t_v1;
	logic [19:0]        t_rawp;
	logic               p_valid;
	logic [63:0]        p_dividend;
	logic signed [30:0] p_divisor;
	side_t              p_side;
	logic               d_valid;
	logic [63:0]        d_quotient;
	side_t              d_side;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_cal_q <= '0;
			press_a_q  <= '0;
			press_b_q  <= '0;
			press_c_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_TEMP_CAL: temp_cal_q <= cfg_data[47:0];
				REG_PRESS_A:  press_a_q  <= cfg_data;
				REG_PRESS_B:  press_b_q  <= cfg_data;
				REG_PRESS_C:  press_c_q  <= cfg_data[15:0];
				default:      temp_cal_q <= temp_cal_q;
			endcase
		end
	end

	assign cal.t1 = temp_cal_q[15:0];
	assign cal.t2 = temp_cal_q[31:16];
	assign cal.t3 = temp_cal_q[47:32];
	assign cal.p1 = press_a_q[15:0];
	assign cal.p2 = press_a_q[31:16];
	assign cal.p3 = press_a_q[47:32];
	assign cal.p4 = press_a_q[63:48];
	assign cal.p5 = press_b_q[15:0];
	assign cal.p6 = press_b_q[31:16];
	assign cal.p7 = press_b_q[47:32];
	assign cal.p8 = press_b_q[63:48];
	assign cal.p9 = press_c_q;

	assign busy = 1'b0;

	pscmp_temp u_temp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start & ~busy),
		.req       (request),
		.cal       (cal),
		.out_valid (t_valid),
		.temp      (t_temp),
		.v1        (t_v1),
		.raw_p     (t_rawp)
	);

	pscmp_press u_press (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (t_valid),
		.temp      (t_temp),
		.v1        (t_v1),
		.raw_p     (t_rawp),
		.cal       (cal),
		.out_valid (p_valid),
		.dividend  (p_dividend),
		.divisor   (p_divisor),
		.side      (p_side)
	);

	pscmp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (p_valid),
		.dividend  (p_dividend),
		.divisor   (p_divisor),
		.side_in   (p_side),
		.out_valid (d_valid),
		.quotient  (d_quotient),
		.side_out  (d_side)
	);

	pscmp_post u_post (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (d_valid),
		.p        (d_quotient),
		.side_in  (d_side),
		.cal      (cal),
		.done     (done),
		.result   (result)
	);

endmodule

[tb/tb.sv]
// self-checking testbench for the pressure sensor compensation top level
module tb;
	import pscmp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int PIPE_LATENCY = 84;
	localparam int DRAIN_CYCLES = PIPE_LATENCY + 10;
	localparam int STALL_LIMIT  = 4000;
	localparam int RANDOM_ITEMS = 1750;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	psc_in_t     request = '0;
	logic        done;
	psc_out_t    result;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_idx = REG_TEMP_CAL;
	logic [63:0] cfg_data = '0;

	// calibration shadow registers
	logic [63:0] temp_cal = '0;
	logic [63:0] press_cal_a = '0;
	logic [63:0] press_cal_b = '0;
	logic [63:0] press_cal_c = '0;

	psc_out_t pending_readings[$];
	int       error_count = 0;
	int       sent_count = 0;
	int       checked_count = 0;
	int       zero_div_count = 0;
	int       config_count = 0;
	int       idle_count = 0;
	bit       idling_on = 1'b1;

	pressure_sensor_compensation_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.request  (request),
		.done     (done),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic psc_out_t compensate_reading(psc_in_t req);
		longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
		longint rt, rp, d1, a1, d2, a2, fine, tw, v1, v2, pv, ps, e1, e2;
		psc_out_t r;
		t1 = temp_cal[15:0];
		t2 = $signed(temp_cal[31:16]);
		t3 = $signed(temp_cal[47:32]);
		p1 = press_cal_a[15:0];
		p2 = $signed(press_cal_a[31:16]);
		p3 = $signed(press_cal_a[47:32]);
		p4 = $signed(press_cal_a[63:48]);
		p5 = $signed(press_cal_b[15:0]);
		p6 = $signed(press_cal_b[31:16]);
		p7 = $signed(press_cal_b[47:32]);
		p8 = $signed(press_cal_b[63:48]);
		p9 = $signed(press_cal_c[15:0]);
		rt = req.raw_temperature;
		rp = req.raw_pressure;

		d1 = (rt >>> 3) - (t1 <<< 1);
		a1 = (d1 * t2) >>> 11;
		d2 = (rt >>> 4) - t1;
		a2 = (((d2 * d2) >>> 12) * t3) >>> 14;
		fine = a1 + a2;
		tw = (fine * 5 + 128) >>> 8;
		if (tw < -32768)
			tw = -32768;
		if (tw > 32767)
			tw = 32767;
		r.temperature_centi = tw[15:0];

		v1 = fine - 128000;
		v2 = v1 * v1 * p6;
		v2 += (v1 * p5) <<< 17;
		v2 += p4 <<< 35;
		v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
		v1 = (((longint'(1) <<< 47) + v1) * p1) >>> 33;
		if (v1 == 0) begin
			r.pressure_q24_8 = '0;
			r.divide_by_zero = 1'b1;
			return r;
		end
		pv = 1048576 - rp;
		pv = ((pv <<< 31) - v2) * 3125;
		// dividing by minus one wraps instead of trapping
		if (v1 == -1)
			pv = -pv;
		else
			pv = pv / v1;
		ps = pv >>> 13;
		e1 = (p9 * ps * ps) >>> 25;
		e2 = (p8 * pv) >>> 19;
		pv = ((pv + e1 + e2) >>> 8) + (p7 <<< 4);
		if (pv < 0)
			r.pressure_q24_8 = '0;
		else if (pv > 33554431)
			r.pressure_q24_8 = PRESS_MAX;
		else
			r.pressure_q24_8 = pv[24:0];
		r.divide_by_zero = 1'b0;
		return r;
	endfunction

	// result checker
	always @(posedge clk) begin
		psc_out_t exp_r;
		if (arst_n && done) begin
			if (pending_readings.size() == 0) begin
				$error("result with no request outstanding");
				error_count++;
			end else begin
				exp_r = pending_readings.pop_front();
				checked_count++;
				if (exp_r.divide_by_zero)
					zero_div_count++;
				if (result.temperature_centi !== exp_r.temperature_centi) begin
					$error("temperature_centi expected %0d actual %0d",
						exp_r.temperature_centi, result.temperature_centi);
					error_count++;
				end
				if (result.pressure_q24_8 !== exp_r.pressure_q24_8) begin
					$error("pressure_q24_8 expected %0d actual %0d",
						exp_r.pressure_q24_8, result.pressure_q24_8);
					error_count++;
				end
				if (result.divide_by_zero !== exp_r.divide_by_zero) begin
					$error("divide_by_zero expected %0b actual %0b",
						exp_r.divide_by_zero, result.divide_by_zero);
					error_count++;
				end
			end
		end
	end

	// watchdog on cycles with no traffic
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_count <= 0;
		else
			idle_count <= idle_count + 1;
		if (idle_count >= STALL_LIMIT) begin
			$display("watchdog: no activity for %0d cycles", STALL_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic send_reading(input logic [19:0] raw_t, input logic [19:0] raw_p);
		psc_in_t req;
		req.raw_temperature = raw_t;
		req.raw_pressure = raw_p;
		start = 1'b1;
		request = req;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_readings.push_back(compensate_reading(req));
		sent_count++;
		@(negedge clk);
	endtask

	task automatic maybe_idle();
		if (idling_on && $urandom_range(0, 7) == 0) begin
			start = 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
	endtask

	task automatic drain_pipeline();
		start = 1'b0;
		while (pending_readings.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_cal(input cfg_reg_t idx, input logic [63:0] data);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_data = data;
		case (idx)
			REG_TEMP_CAL: temp_cal = {16'h0, data[47:0]};
			REG_PRESS_A:  press_cal_a = data;
			REG_PRESS_B:  press_cal_b = data;
			REG_PRESS_C:  press_cal_c = {48'h0, data[15:0]};
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
		config_count++;
	endtask

	task automatic load_calibration(input logic [63:0] tc, input logic [63:0] pa,
			input logic [63:0] pb, input logic [63:0] pc);
		drain_pipeline();
		write_cal(REG_TEMP_CAL, tc);
		write_cal(REG_PRESS_A, pa);
		write_cal(REG_PRESS_B, pb);
		write_cal(REG_PRESS_C, pc);
	endtask

	task automatic load_typical();
		load_calibration({16'hDEAD, 16'hFC18, 16'd26435, 16'd27504},
			{16'd2855, 16'd3024, 16'hD643, 16'd36477},
			{16'hC6F8, 16'd15500, 16'hFFF9, 16'd140},
			{48'hBEEF_0000_0000, 16'd6000});
	endtask

	task automatic load_random_cal();
		load_calibration({$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom}, {$urandom, $urandom});
	endtask

	task automatic test_reset_calibration();
		// all-zero calibration makes the divisor zero
		send_reading(20'd519888, 20'd415148);
		send_reading(20'hFFFFF, 20'h00000);
		send_reading(20'h00000, 20'hFFFFF);
	endtask

	task automatic test_directed_typical();
		load_typical();
		send_reading(20'd519888, 20'd415148);
		send_reading(20'h00000, 20'h00000);
		send_reading(20'hFFFFF, 20'hFFFFF);
		send_reading(20'h00000, 20'hFFFFF);
		send_reading(20'hFFFFF, 20'h00000);
		send_reading(20'h80000, 20'h80000);
		send_reading(20'h55555, 20'hAAAAA);
		send_reading(20'hAAAAA, 20'h55555);
	endtask

	task automatic test_extreme_calibration();
		load_calibration(64'hFFFF_FFFF_FFFF, '1, '1, 64'hFFFF);
		send_reading(20'h00000, 20'h00000);
		send_reading(20'hFFFFF, 20'hFFFFF);
		load_calibration(64'h7FFF_7FFF_FFFF, 64'h7FFF_7FFF_7FFF_FFFF,
			64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF);
		send_reading(20'h00000, 20'h00000);
		send_reading(20'hFFFFF, 20'hFFFFF);
		load_calibration(64'h8000_8000_0000, 64'h8000_8000_8000_0001,
			64'h8000_8000_8000_8000, 64'h8000);
		send_reading(20'h00000, 20'hFFFFF);
		send_reading(20'hFFFFF, 20'h00000);
		// p1 zero forces the zero divisor with live temperature
		load_calibration({16'h0, 16'hFC18, 16'd26435, 16'd27504}, 64'h0,
			64'h1234_5678_9ABC_DEF0, 64'h1);
		send_reading(20'd519888, 20'd415148);
		send_reading(20'hFFFFF, 20'h12345);
	endtask

	task automatic test_random_stream();
		int phase;
		for (phase = 0; phase < 7; phase++) begin
			if (phase % 2 == 0)
				load_typical();
			else
				load_random_cal();
			if (phase == 6)
				idling_on = 1'b0;
			repeat (RANDOM_ITEMS / 7) begin
				maybe_idle();
				if ($urandom_range(0, 3) == 0)
					send_reading(20'($urandom), 20'($urandom));
				else
					send_reading(20'($urandom_range(400000, 600000)),
						20'($urandom_range(200000, 700000)));
			end
			// hold off once mid-run until everything is back
			if (phase == 2) begin
				start = 1'b0;
				while (pending_readings.size() != 0)
					@(negedge clk);
			end
		end
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_calibration();
		test_directed_typical();
		test_extreme_calibration();
		test_random_stream();
		drain_pipeline();
		$display("sent %0d readings, checked %0d results (%0d zero divisor), %0d cal writes",
			sent_count, checked_count, zero_div_count, config_count);
		if (error_count == 0 && pending_readings.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches, %0d results missing", error_count,
				pending_readings.size());
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
